[rtl/core/glos_pkg.sv]
// Shared types and constants for the grid line-of-sight block.
// Holds field widths, stream bit positions, register indexes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package glos_pkg;

    localparam int COORD_W    = 16;
    localparam int CELL_W     = 6;
    localparam int DIM_W      = 7;
    localparam int TILE_W     = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 8;
    localparam int DIV_LANES  = 4;
    localparam int ACC_W      = COORD_W + 1;

    // Bit positions of the input fields inside s_tdata.
    localparam int CELL_X_LSB     = 0;
    localparam int CELL_Y_LSB     = 6;
    localparam int CELL_SOLID_BIT = 12;
    localparam int START_X_LSB    = 13;
    localparam int START_Y_LSB    = 29;
    localparam int END_X_LSB      = 45;
    localparam int END_Y_LSB      = 61;

    // Divider lanes.
    localparam int LANE_SX = 0;
    localparam int LANE_SY = 1;
    localparam int LANE_EX = 2;
    localparam int LANE_EY = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE  = 2'd2;

    localparam logic [DIM_W-1:0]  MAP_WIDTH_RST  = 7'd64;
    localparam logic [DIM_W-1:0]  MAP_HEIGHT_RST = 7'd64;
    localparam logic [TILE_W-1:0] TILE_SIZE_RST  = 8'd32;

    // Item kinds carried in s_tuser.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_WALK,
        ST_RESULT
    } glos_state_t;

    typedef struct packed {
        logic clear_step;
        logic cell_write;
        logic query_load;
        logic setup;
        logic walk_step;
        logic out_load;
    } glos_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_done;
        logic walk_done;
        logic out_free;
    } glos_stat_t;

endpackage

[rtl/core/grid_line_of_sight_top.sv]
// Top level of the grid line-of-sight block: stream ports, configuration
// port, controller and datapath. Depends on glos_pkg, glos_ctrl, glos_dp.
`timescale 1ns / 1ps

// The block keeps a one-bit solid/empty map of MAX_COLUMNS x MAX_ROWS cells
// and answers line-of-sight queries over it. After reset it sweeps all
// 2**(clog2(MAX_COLUMNS) + clog2(MAX_ROWS)) grid memory cells (4096 at the
// defaults) to empty, with s_tready low; configuration writes are taken
// during that time. A write beat (s_tuser = 0) sets one cell, and the next
// beat can follow at once. A query beat (s_tuser = 1) divides its four
// pixel coordinates by tile_size in a bit-serial divider (all four lanes
// together), then does the line setup, then walks one cell per cycle
// through the grid memory, whose read is registered. The walk stops at the
// first solid cell in the map, at the end point, or once the line has
// passed the far edge of the map in its direction of travel. A query walks
// at most the longer cell distance plus one cells. Only one query is in
// work at a time. The result sits in an output register, so a new beat is
// taken while an earlier result waits on m_tready; a finished query waits
// for that register to free before the next beat is taken. Configuration
// is meant to change only while the block is idle.

module grid_line_of_sight_top #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [glos_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [glos_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // From bit 0: cell_x[5:0], cell_y[11:6], cell_solid[12], start_x[28:13],
    // start_y[44:29], end_x[60:45], end_y[76:61], zero fill [79:77].
    input  logic [glos_pkg::S_TDATA_W-1:0]   s_tdata,
    // From bit 0: mode (0 writes a cell, 1 asks a query).
    input  logic                             s_tuser,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // From bit 0: line_blocked[0], zero fill [7:1].
    output logic [glos_pkg::M_TDATA_W-1:0]   m_tdata
);
    import glos_pkg::*;

    glos_cmd_t  cmd;
    glos_stat_t stat;
    logic       blocked;

    // The controller sequences the clear sweep, intake, division, setup,
    // walk and result hand-off; the datapath follows its commands.
    glos_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    glos_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_data      (s_tdata),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_blocked  (blocked)
    );

    assign m_tdata = {{(M_TDATA_W - 1){1'b0}}, blocked};

endmodule

[rtl/core/glos_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module glos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/glos_div.sv]
// Four-lane restoring divider: pixel coordinates by the tile size.
// One quotient bit per lane per cycle. Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_div (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  start,
    input  logic [glos_pkg::DIV_LANES-1:0][glos_pkg::COORD_W-1:0] dividend,
    input  logic [glos_pkg::TILE_W-1:0]                           divisor,
    output logic                                                  done,
    output logic [glos_pkg::DIV_LANES-1:0][glos_pkg::COORD_W-1:0] quotient
);
    import glos_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);

    logic                                  busy_reg, busy_next;
    logic [CNT_W-1:0]                      cnt_reg, cnt_next;
    logic [TILE_W-1:0]                     dsr_reg, dsr_next;
    logic [DIV_LANES-1:0][COORD_W-1:0]     quo_reg, quo_next;
    logic [DIV_LANES-1:0][TILE_W-1:0]      rem_reg, rem_next;
    logic [TILE_W:0]                       shifted;
    logic                                  ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(COORD_W - 1));

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        shifted   = '0;
        ge        = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (done) begin
                busy_next = 1'b0;
            end
            // The dividend shifts out at the top while quotient bits enter below.
            for (int l = 0; l < DIV_LANES; l++) begin
                shifted     = {rem_reg[l], quo_reg[l][COORD_W-1]};
                ge          = shifted >= {1'b0, dsr_reg};
                rem_next[l] = ge ? TILE_W'(shifted - {1'b0, dsr_reg}) : shifted[TILE_W-1:0];
                quo_next[l] = {quo_reg[l][COORD_W-2:0], ge};
            end
        end
    end

    assign quotient = quo_reg;

endmodule

[rtl/core/glos_ctrl.sv]
// Controller state machine: clear pass, item intake, divide, setup, walk
// and result hand-off. Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_mode,
    output logic                 in_ready,
    output glos_pkg::glos_cmd_t  cmd,
    input  glos_pkg::glos_stat_t stat
);
    import glos_pkg::*;

    glos_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (stat.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_valid && (in_mode == MODE_QUERY)) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (stat.walk_done) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                in_ready       = 1'b1;
                cmd.cell_write = in_valid && (in_mode == MODE_WRITE);
                cmd.query_load = in_valid && (in_mode == MODE_QUERY);
            end
            ST_DIV: begin
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
            end
            ST_RESULT: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/core/glos_dp.sv]
// Datapath: configuration registers, grid memory, tile divider, line-walk
// registers and the output register. Depends on glos_pkg, glos_ram, glos_div.
`timescale 1ns / 1ps

module glos_dp #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [glos_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [glos_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [glos_pkg::S_TDATA_W-1:0]   in_data,
    input  glos_pkg::glos_cmd_t              cmd,
    output glos_pkg::glos_stat_t             stat,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic                             out_blocked
);
    import glos_pkg::*;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int AW      = COL_W + ROW_W;
    localparam int DEPTH   = 1 << AW;
    localparam int COLS_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_W  = $clog2(MAX_ROWS + 1);

    // Configuration.
    logic [DIM_W-1:0]  map_width_reg, map_height_reg;
    logic [TILE_W-1:0] tile_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= MAP_WIDTH_RST;
            map_height_reg <= MAP_HEIGHT_RST;
            tile_size_reg  <= TILE_SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_wr_data[DIM_W-1:0];
                CFG_MAP_HEIGHT: map_height_reg <= cfg_wr_data[DIM_W-1:0];
                CFG_TILE_SIZE:  tile_size_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Tile divider.
    logic [DIV_LANES-1:0][COORD_W-1:0] dividend, quotient;
    logic [TILE_W-1:0]                 tile_eff;
    logic                              div_done;

    assign tile_eff = (tile_size_reg == '0) ? TILE_W'(1) : tile_size_reg;

    always_comb begin
        dividend          = '0;
        dividend[LANE_SX] = in_data[START_X_LSB +: COORD_W];
        dividend[LANE_SY] = in_data[START_Y_LSB +: COORD_W];
        dividend[LANE_EX] = in_data[END_X_LSB +: COORD_W];
        dividend[LANE_EY] = in_data[END_Y_LSB +: COORD_W];
    end

    glos_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.query_load),
        .dividend (dividend),
        .divisor  (tile_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    // Line setup.
    logic [COORD_W:0]   w_diff, h_diff;
    logic [COORD_W-1:0] w_abs, h_abs, longest, shortest;
    logic               swap;
    logic [COLS_W-1:0]  cols_eff;
    logic [ROWS_W-1:0]  rows_eff;

    assign w_diff   = {1'b0, quotient[LANE_EX]} - {1'b0, quotient[LANE_SX]};
    assign h_diff   = {1'b0, quotient[LANE_EY]} - {1'b0, quotient[LANE_SY]};
    assign w_abs    = w_diff[COORD_W] ? COORD_W'(-w_diff) : w_diff[COORD_W-1:0];
    assign h_abs    = h_diff[COORD_W] ? COORD_W'(-h_diff) : h_diff[COORD_W-1:0];
    assign swap     = w_abs <= h_abs;
    assign longest  = swap ? h_abs : w_abs;
    assign shortest = swap ? w_abs : h_abs;
    assign cols_eff = (COORD_W'(map_width_reg) > COORD_W'(MAX_COLUMNS))
                    ? COLS_W'(MAX_COLUMNS) : COLS_W'(map_width_reg);
    assign rows_eff = (COORD_W'(map_height_reg) > COORD_W'(MAX_ROWS))
                    ? ROWS_W'(MAX_ROWS) : ROWS_W'(map_height_reg);

    // Walk registers.
    logic [COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [COORD_W-1:0] steps_reg, steps_next;
    logic [COORD_W-1:0] longest_reg, longest_next, shortest_reg, shortest_next;
    logic               x_neg_reg, x_neg_next, y_neg_reg, y_neg_next;
    logic               x_maj_reg, x_maj_next, x_min_reg, x_min_next;
    logic               y_maj_reg, y_maj_next, y_min_reg, y_min_next;
    logic [COLS_W-1:0]  cols_reg, cols_next;
    logic [ROWS_W-1:0]  rows_reg, rows_next;
    logic               issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic               pend_in_reg, pend_in_next;
    logic               pend_last_reg, pend_last_next;
    logic               res_reg, res_next;

    logic               in_map, leaving, last_cell, take_major, hit;
    logic [ACC_W-1:0]   acc_sum;

    assign in_map    = (x_reg < COORD_W'(cols_reg)) && (y_reg < COORD_W'(rows_reg));
    // Coordinates only move toward the end point, so a cell past the far
    // edge in the direction of travel means no later cell can be in the map.
    assign leaving   = ((x_reg >= COORD_W'(cols_reg)) && !x_neg_reg)
                    || ((y_reg >= COORD_W'(rows_reg)) && !y_neg_reg);
    assign last_cell = (steps_reg == '0) || leaving;
    assign acc_sum   = acc_reg + ACC_W'(shortest_reg);
    assign take_major = acc_sum >= ACC_W'(longest_reg);

    logic ram_rdata;
    assign hit = pend_reg && pend_in_reg && ram_rdata;

    always_comb begin
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        steps_next     = steps_reg;
        longest_next   = longest_reg;
        shortest_next  = shortest_reg;
        x_neg_next     = x_neg_reg;
        y_neg_next     = y_neg_reg;
        x_maj_next     = x_maj_reg;
        x_min_next     = x_min_reg;
        y_maj_next     = y_maj_reg;
        y_min_next     = y_min_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        issue_next     = issue_reg;
        res_next       = res_reg;
        pend_next      = cmd.walk_step && issue_reg;
        pend_in_next   = in_map;
        pend_last_next = last_cell;
        if (cmd.setup) begin
            x_next        = quotient[LANE_SX];
            y_next        = quotient[LANE_SY];
            acc_next      = ACC_W'(longest >> 1);
            steps_next    = longest;
            longest_next  = longest;
            shortest_next = shortest;
            x_neg_next    = w_diff[COORD_W];
            y_neg_next    = h_diff[COORD_W];
            x_maj_next    = (w_diff != '0);
            x_min_next    = (w_diff != '0) && !swap;
            y_maj_next    = (h_diff != '0);
            y_min_next    = (h_diff != '0) && swap;
            cols_next     = cols_eff;
            rows_next     = rows_eff;
            issue_next    = 1'b1;
        end else if (cmd.walk_step) begin
            if (pend_reg) begin
                res_next = hit;
            end
            if (issue_reg) begin
                issue_next = !last_cell;
                steps_next = steps_reg - COORD_W'(1);
                acc_next   = take_major ? (acc_sum - ACC_W'(longest_reg)) : acc_sum;
                if (take_major ? x_maj_reg : x_min_reg) begin
                    x_next = x_neg_reg ? (x_reg - COORD_W'(1)) : (x_reg + COORD_W'(1));
                end
                if (take_major ? y_maj_reg : y_min_reg) begin
                    y_next = y_neg_reg ? (y_reg - COORD_W'(1)) : (y_reg + COORD_W'(1));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
        x_reg         <= x_next;
        y_reg         <= y_next;
        acc_reg       <= acc_next;
        steps_reg     <= steps_next;
        longest_reg   <= longest_next;
        shortest_reg  <= shortest_next;
        x_neg_reg     <= x_neg_next;
        y_neg_reg     <= y_neg_next;
        x_maj_reg     <= x_maj_next;
        x_min_reg     <= x_min_next;
        y_maj_reg     <= y_maj_next;
        y_min_reg     <= y_min_next;
        cols_reg      <= cols_next;
        rows_reg      <= rows_next;
        pend_in_reg   <= pend_in_next;
        pend_last_reg <= pend_last_next;
        res_reg       <= res_next;
    end

    // Grid memory and the clear sweep.
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [COORD_W-1:0] wr_x, wr_y;
    logic               wr_in_store;
    logic               ram_wr_en, ram_wr_data;
    logic [AW-1:0]      ram_wr_addr, ram_rd_addr;

    assign wr_x        = COORD_W'(in_data[CELL_X_LSB +: CELL_W]);
    assign wr_y        = COORD_W'(in_data[CELL_Y_LSB +: CELL_W]);
    assign wr_in_store = (wr_x < COORD_W'(MAX_COLUMNS)) && (wr_y < COORD_W'(MAX_ROWS));
    assign clr_cnt_next = cmd.clear_step ? (clr_cnt_reg + AW'(1)) : clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = {wr_y[ROW_W-1:0], wr_x[COL_W-1:0]};
        ram_wr_data = in_data[CELL_SOLID_BIT];
        if (cmd.clear_step) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = 1'b0;
        end else if (cmd.cell_write && wr_in_store) begin
            ram_wr_en = 1'b1;
        end
    end

    assign ram_rd_addr = {y_reg[ROW_W-1:0], x_reg[COL_W-1:0]};

    glos_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rdata)
    );

    // Output register.
    logic out_valid_reg, out_valid_next;
    logic out_data_reg, out_data_next;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_blocked = out_data_reg;

    assign stat.clear_last = clr_cnt_reg == {AW{1'b1}};
    assign stat.div_done   = div_done;
    assign stat.walk_done  = hit || (pend_reg && pend_last_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

[rtl/core/glos_checker.sv]
// Port-level checker for grid_line_of_sight_top and the bind that attaches it.
// Depends on glos_pkg and grid_line_of_sight_top.
`timescale 1ns / 1ps

module glos_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [glos_pkg::M_TDATA_W-1:0]  m_tdata
);
    import glos_pkg::*;

    // A waiting result beat holds its value until it is taken.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    // A query occupies the block: intake closes right after it is taken.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == MODE_QUERY)) |=> !s_tready)
        else $error("input taken while a query is in work");

    // A cell write finishes in its own cycle and leaves intake open.
    a_write_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == MODE_WRITE)) |=> s_tready)
        else $error("cell write stalled the input");

    // A new result appears exactly when the block returns to idle.
    a_result_at_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while the block is still busy");

    // The map sweep after reset keeps the input closed at first.
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_tready)
        else $error("input open before the map sweep");

endmodule

bind grid_line_of_sight_top glos_checker u_glos_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
